// ===== rtl/pidt_pkg.sv =====
`default_nettype none
package pidt_pkg;

  localparam int PORT_W      = 16;
  localparam int BM_BYTES    = 8192;
  localparam int BM_ADDR_W   = 13;
  localparam int WIDTH_SET_W = 3;
  localparam int SLOT_OUT_W  = 4;

  localparam logic REQ_REGISTER = 1'b0;
  localparam logic REQ_DISPATCH = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
  localparam logic [1:0] STATUS_WIDTH    = 2'd2;
  localparam logic [1:0] STATUS_STRING   = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG_SCAN,
    ST_DISP_SCAN,
    ST_BITMAP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [PORT_W-1:0]      port;
    logic [WIDTH_SET_W-1:0] width_set;
    logic                   has_read;
    logic                   has_write;
  } slot_entry_t;

  typedef struct packed {
    logic              valid;
    logic [PORT_W-1:0] port;
  } bm_req_t;

  typedef struct packed {
    logic       clearing;
    logic       done;
    logic [7:0] value;
  } bm_status_t;

endpackage
`default_nettype wire

// ===== rtl/port_io_dispatch_table.sv =====
`default_nettype none
// Result path: a register item scans the slots up to the first free slot k, then runs the
// bitmap read-modify-write; a full table answers with STATUS_NO_SPACE after the whole scan.
// A dispatch item scans to a hit on slot j or to a miss at the last slot; strings skip the scan.
// One item at a time: the next transfer is taken only once the result is in the output
// register, and a stalled result holds the input off. Reset: a clearing pass over the
// 8192-byte intercept bitmap runs with in_stall high; slot used bits clear at once.
module port_io_dispatch_table #(
  parameter int SLOT_COUNT = 16
) (
  input  wire         clk,
  input  wire         rst,
  // input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         req_type,
  input  wire  [15:0] reg_port,
  input  wire  [2:0]  reg_width_set,
  input  wire         reg_has_read,
  input  wire         reg_has_write,
  input  wire  [31:0] exit_info,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  status,
  output logic [3:0]  slot_index,
  output logic        use_default,
  output logic        invoke_handler,
  output logic        is_write,
  output logic [15:0] access_port,
  output logic [3:0]  access_size,
  output logic [12:0] bitmap_byte_index,
  output logic [7:0]  bitmap_byte_value
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IW-1:0] LAST = IW'(SLOT_COUNT - 1);

  // Slot table: used bits in flops, entry payload in a memory read one slot per cycle.
  logic [SLOT_COUNT-1:0]  used;
  pidt_pkg::slot_entry_t  slot_mem [SLOT_COUNT];
  pidt_pkg::slot_entry_t  slot_rd;
  pidt_pkg::slot_entry_t  slot_wr;
  logic                   mem_we;

  pidt_pkg::state_t state, state_next;
  logic [IW-1:0]    idx, idx_next;
  logic             chk_valid, chk_valid_next;
  logic [IW-1:0]    chk_idx;

  // captured item
  logic        type_q;
  logic [15:0] port_q;
  logic [2:0]  mask_q;
  logic        rd_q;
  logic        wr_q;

  // result being built
  logic [1:0]  res_status;
  logic [3:0]  res_slot;
  logic        res_default;
  logic        res_invoke;
  logic        res_wr;
  logic [15:0] res_port;
  logic [3:0]  res_size;
  logic [12:0] res_bidx;
  logic [7:0]  res_bval;

  logic                 accept;
  logic                 out_load;
  logic                 free_hit;
  logic                 table_full;
  logic                 disp_hit;
  logic                 disp_miss;
  logic                 size_ok;
  logic [IW+3:0]        idx_wide;
  logic [IW+3:0]        chk_wide;
  logic [3:0]           q_size;
  pidt_pkg::bm_req_t    bm_req;
  pidt_pkg::bm_status_t bm_st;

  pidt_bitmap u_bitmap (
    .clk    (clk),
    .rst    (rst),
    .req    (bm_req),
    .status (bm_st)
  );

  // Hold off new items while busy or while the bitmap is still being cleared.
  assign in_stall = (state != pidt_pkg::ST_IDLE) || bm_st.clearing;
  assign accept   = in_valid && !in_stall;

  // Reported slot index wraps modulo 16.
  assign idx_wide = {4'd0, idx};
  assign chk_wide = {4'd0, chk_idx};
  assign q_size   = {1'b0, exit_info[2:0]} + 4'd1;

  // Register scan: first unused slot in index order.
  assign free_hit   = (state == pidt_pkg::ST_REG_SCAN) && !used[idx];
  assign table_full = (state == pidt_pkg::ST_REG_SCAN) && used[idx] && (idx == LAST);

  // Dispatch scan: slot_rd holds the entry of chk_idx, read the cycle before.
  assign size_ok   = ((res_size == 4'd1) || (res_size == 4'd2) || (res_size == 4'd4)) &&
                     ((res_size[2:0] & slot_rd.width_set) != 3'd0);
  assign disp_hit  = (state == pidt_pkg::ST_DISP_SCAN) && chk_valid && used[chk_idx] &&
                     (slot_rd.port == res_port);
  assign disp_miss = (state == pidt_pkg::ST_DISP_SCAN) && chk_valid && !disp_hit &&
                     (chk_idx == LAST);

  assign mem_we  = free_hit;
  assign slot_wr = '{port: port_q, width_set: mask_q, has_read: rd_q, has_write: wr_q};
  assign bm_req  = '{valid: free_hit, port: port_q};

  // Load the output register once the previous result has gone out.
  assign out_load = (state == pidt_pkg::ST_DONE) && (!out_valid || !out_stall);

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    chk_valid_next = 1'b0;
    case (state)
      pidt_pkg::ST_IDLE: begin
        idx_next = '0;
        if (accept) begin
          if (req_type == pidt_pkg::REQ_REGISTER) begin
            state_next = pidt_pkg::ST_REG_SCAN;
          end else if (exit_info[4]) begin
            state_next = pidt_pkg::ST_DONE;
          end else begin
            state_next = pidt_pkg::ST_DISP_SCAN;
          end
        end
      end
      pidt_pkg::ST_REG_SCAN: begin
        if (free_hit) begin
          state_next = pidt_pkg::ST_BITMAP;
        end else if (table_full) begin
          state_next = pidt_pkg::ST_DONE;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      pidt_pkg::ST_DISP_SCAN: begin
        if (disp_hit || disp_miss) begin
          state_next = pidt_pkg::ST_DONE;
        end else begin
          chk_valid_next = 1'b1;
          if (idx != LAST) begin
            idx_next = idx + 1'b1;
          end
        end
      end
      pidt_pkg::ST_BITMAP: begin
        if (bm_st.done) begin
          state_next = pidt_pkg::ST_DONE;
        end
      end
      pidt_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = pidt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pidt_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pidt_pkg::ST_IDLE;
      idx       <= '0;
      chk_valid <= 1'b0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      chk_valid <= chk_valid_next;
      if (free_hit) begin
        used[idx] <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Slot memory: one write port, one registered read port driven by the scan index.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[idx] <= slot_wr;
    end
    slot_rd <= slot_mem[idx];
    chk_idx <= idx;
  end

  // Build the result as the sequencer goes.
  always_ff @(posedge clk) begin
    if (accept) begin
      type_q      <= req_type;
      port_q      <= reg_port;
      mask_q      <= reg_width_set;
      rd_q        <= reg_has_read;
      wr_q        <= reg_has_write;
      res_status  <= ((req_type == pidt_pkg::REQ_DISPATCH) && exit_info[4]) ?
                     pidt_pkg::STATUS_STRING : pidt_pkg::STATUS_OK;
      res_slot    <= 4'd0;
      res_default <= 1'b0;
      res_invoke  <= 1'b0;
      res_bidx    <= 13'd0;
      res_bval    <= 8'd0;
      if (req_type == pidt_pkg::REQ_DISPATCH) begin
        res_wr   <= !exit_info[3];
        res_port <= exit_info[31:16];
        res_size <= q_size;
      end else begin
        res_wr   <= 1'b0;
        res_port <= 16'd0;
        res_size <= 4'd0;
      end
    end
    if (free_hit) begin
      res_slot <= idx_wide[3:0];
      res_bidx <= port_q[15:3];
    end
    if (table_full) begin
      res_status <= pidt_pkg::STATUS_NO_SPACE;
    end
    if ((state == pidt_pkg::ST_BITMAP) && bm_st.done) begin
      res_bval <= bm_st.value;
    end
    if (disp_hit) begin
      res_slot <= chk_wide[3:0];
      if (size_ok) begin
        res_invoke <= res_wr ? slot_rd.has_write : slot_rd.has_read;
      end else begin
        res_status <= pidt_pkg::STATUS_WIDTH;
      end
    end
    if (disp_miss) begin
      res_default <= 1'b1;
      res_invoke  <= 1'b1;
    end
  end

  // Output register; holds while stalled.
  always_ff @(posedge clk) begin
    if (out_load) begin
      status            <= res_status;
      slot_index        <= res_slot;
      use_default       <= res_default;
      invoke_handler    <= res_invoke;
      is_write          <= (type_q == pidt_pkg::REQ_DISPATCH) ? res_wr : 1'b0;
      access_port       <= res_port;
      access_size       <= res_size;
      bitmap_byte_index <= res_bidx;
      bitmap_byte_value <= res_bval;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pidt_bitmap.sv =====
`default_nettype none
module pidt_bitmap (
  input  wire                       clk,
  input  wire                       rst,
  input  wire pidt_pkg::bm_req_t    req,
  output pidt_pkg::bm_status_t      status
);

  localparam logic [pidt_pkg::BM_ADDR_W-1:0] BM_LAST =
    pidt_pkg::BM_ADDR_W'(pidt_pkg::BM_BYTES - 1);

  logic [7:0] mem [pidt_pkg::BM_BYTES];

  logic                           clearing;
  logic [pidt_pkg::BM_ADDR_W-1:0] clr_addr;
  logic                           rd_pend;
  logic                           done;
  logic [pidt_pkg::BM_ADDR_W-1:0] addr_q;
  logic [2:0]                     bit_q;
  logic [7:0]                     rd_data;
  logic [7:0]                     value_q;
  logic [7:0]                     merged;
  logic                           we;
  logic [pidt_pkg::BM_ADDR_W-1:0] wr_addr;
  logic [7:0]                     wr_data;

  // read-modify-write: set one bit in the byte read the cycle before
  always_comb begin
    merged  = rd_data | (8'd1 << bit_q);
    we      = clearing || rd_pend;
    wr_addr = clearing ? clr_addr : addr_q;
    wr_data = clearing ? 8'd0 : merged;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (req.valid) begin
      rd_data <= mem[req.port[pidt_pkg::PORT_W-1:3]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
      done     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == BM_LAST) begin
          clearing <= 1'b0;
        end
      end
      rd_pend <= req.valid;
      done    <= rd_pend;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      addr_q <= req.port[pidt_pkg::PORT_W-1:3];
      bit_q  <= req.port[2:0];
    end
    if (rd_pend) begin
      value_q <= merged;
    end
  end

  assign status = '{clearing: clearing, done: done, value: value_q};

endmodule
`default_nettype wire

// ===== dv/port_io_dispatch_table_tb.sv =====
`default_nettype none
module port_io_dispatch_table_tb;

  localparam int SLOT_COUNT = 16;
  // Exit qualification layout: size-1 in 2:0, direction and string flags, port on top.
  localparam int QUAL_IN  = 3;
  localparam int QUAL_STR = 4;
  localparam int RANDOM_ITEMS = 900;
  localparam int IDLE_PCT = 38;
  // Transfer window with no idling on either side.
  localparam int CALM_FIRST = 450;
  localparam int CALM_LAST  = 600;

  // One input transfer as the driver presents it; drain_first holds the item back
  // until every outstanding decision has come out.
  typedef struct packed {
    logic                             req_type;
    logic [pidt_pkg::PORT_W-1:0]      reg_port;
    logic [pidt_pkg::WIDTH_SET_W-1:0] reg_width_set;
    logic                             reg_has_read;
    logic                             reg_has_write;
    logic [31:0]                      exit_info;
    logic                             drain_first;
  } io_item_t;

  // One dispatch/registration decision as the block reports it.
  typedef struct packed {
    logic [1:0]                     status;
    logic [pidt_pkg::SLOT_OUT_W-1:0] slot_index;
    logic                           use_default;
    logic                           invoke_handler;
    logic                           is_write;
    logic [pidt_pkg::PORT_W-1:0]    access_port;
    logic [3:0]                     access_size;
    logic [pidt_pkg::BM_ADDR_W-1:0] bitmap_byte_index;
    logic [7:0]                     bitmap_byte_value;
  } decision_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   in_valid      = 1'b0;
  logic                   in_stall;
  logic                   req_type      = 1'b0;
  logic [15:0]            reg_port      = '0;
  logic [2:0]             reg_width_set = '0;
  logic                   reg_has_read  = 1'b0;
  logic                   reg_has_write = 1'b0;
  logic [31:0]            exit_info     = '0;
  logic                   out_valid;
  logic                   out_stall     = 1'b0;
  logic [1:0]             status;
  logic [3:0]             slot_index;
  logic                   use_default;
  logic                   invoke_handler;
  logic                   is_write;
  logic [15:0]            access_port;
  logic [3:0]             access_size;
  logic [12:0]            bitmap_byte_index;
  logic [7:0]             bitmap_byte_value;

  port_io_dispatch_table #(.SLOT_COUNT(SLOT_COUNT)) DUT (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .req_type          (req_type),
    .reg_port          (reg_port),
    .reg_width_set     (reg_width_set),
    .reg_has_read      (reg_has_read),
    .reg_has_write     (reg_has_write),
    .exit_info         (exit_info),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .slot_index        (slot_index),
    .use_default       (use_default),
    .invoke_handler    (invoke_handler),
    .is_write          (is_write),
    .access_port       (access_port),
    .access_size       (access_size),
    .bitmap_byte_index (bitmap_byte_index),
    .bitmap_byte_value (bitmap_byte_value)
  );

  // Free-running clock, period 4.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the handler table and the intercept bitmap.
  logic                             slot_taken [SLOT_COUNT];
  logic [pidt_pkg::PORT_W-1:0]      slot_port  [SLOT_COUNT];
  logic [pidt_pkg::WIDTH_SET_W-1:0] slot_mask  [SLOT_COUNT];
  logic                             slot_rd    [SLOT_COUNT];
  logic                             slot_wr    [SLOT_COUNT];
  logic [7:0]                       bitmap_copy [pidt_pkg::BM_BYTES];

  io_item_t  pending [$];      // items still to be sent
  decision_t decision_q [$];   // decisions owed by the block, oldest first
  io_item_t  cur;              // item currently on the input channel
  decision_t observed;
  decision_t wanted;

  int xfer_count = 0;
  int result_count = 0;
  int mismatches = 0;
  int total_items = 0;
  int n_register = 0, n_nospace = 0, n_ok = 0, n_default = 0, n_width = 0, n_string = 0;

  logic calm;
  assign calm = (xfer_count >= CALM_FIRST) && (xfer_count < CALM_LAST);

  // Compute the decision for one accepted transfer and advance the shadow state.
  function automatic decision_t dispatch_decide(io_item_t it);
    decision_t d;
    int i;
    int free_slot;
    int hit;
    logic [pidt_pkg::BM_ADDR_W-1:0] byte_idx;
    logic [pidt_pkg::PORT_W-1:0] p;
    logic [3:0] sz;
    logic wr;
    logic size_ok;
    d = '0;
    if (it.req_type == pidt_pkg::REQ_REGISTER) begin
      n_register++;
      // Take the lowest free slot.
      free_slot = -1;
      for (i = 0; i < SLOT_COUNT; i++)
        if (free_slot < 0 && !slot_taken[i]) free_slot = i;
      if (free_slot < 0) begin
        d.status = pidt_pkg::STATUS_NO_SPACE;
        n_nospace++;
      end else begin
        slot_taken[free_slot] = 1'b1;
        slot_port[free_slot]  = it.reg_port;
        slot_mask[free_slot]  = it.reg_width_set;
        slot_rd[free_slot]    = it.reg_has_read;
        slot_wr[free_slot]    = it.reg_has_write;
        byte_idx = it.reg_port[15:3];
        bitmap_copy[byte_idx] = bitmap_copy[byte_idx] | (8'd1 << it.reg_port[2:0]);
        d.status            = pidt_pkg::STATUS_OK;
        d.slot_index        = 4'(free_slot);
        d.bitmap_byte_index = byte_idx;
        d.bitmap_byte_value = bitmap_copy[byte_idx];
      end
    end else begin
      // Decode port, size and direction regardless of the outcome.
      p  = it.exit_info[31:16];
      sz = {1'b0, it.exit_info[2:0]} + 4'd1;
      wr = !it.exit_info[QUAL_IN];
      d.is_write    = wr;
      d.access_port = p;
      d.access_size = sz;
      if (it.exit_info[QUAL_STR]) begin
        d.status = pidt_pkg::STATUS_STRING;
        n_string++;
      end else begin
        // First used slot with a matching port decides.
        hit = -1;
        for (i = 0; i < SLOT_COUNT; i++)
          if (hit < 0 && slot_taken[i] && slot_port[i] == p) hit = i;
        if (hit < 0) begin
          d.status         = pidt_pkg::STATUS_OK;
          d.use_default    = 1'b1;
          d.invoke_handler = 1'b1;
          n_default++;
        end else begin
          d.slot_index = 4'(hit);
          size_ok = (sz == 4'd1 || sz == 4'd2 || sz == 4'd4) &&
                    (({1'b0, slot_mask[hit]} & sz) != 4'd0);
          if (size_ok) begin
            d.status         = pidt_pkg::STATUS_OK;
            d.invoke_handler = wr ? slot_wr[hit] : slot_rd[hit];
            n_ok++;
          end else begin
            d.status = pidt_pkg::STATUS_WIDTH;
            n_width++;
          end
        end
      end
    end
    return d;
  endfunction

  function automatic string fmt_decision(decision_t d);
    return $sformatf("st=%0d slot=%0d dflt=%0d inv=%0d wr=%0d port=%h sz=%0d byte=%0d val=%h",
                     d.status, d.slot_index, d.use_default, d.invoke_handler, d.is_write,
                     d.access_port, d.access_size, d.bitmap_byte_index, d.bitmap_byte_value);
  endfunction

  // Register item; the exit qualification carries random noise.
  function automatic io_item_t make_register(logic [15:0] p, logic [2:0] m, logic rd, logic wr);
    io_item_t it;
    it.req_type      = pidt_pkg::REQ_REGISTER;
    it.reg_port      = p;
    it.reg_width_set = m;
    it.reg_has_read  = rd;
    it.reg_has_write = wr;
    it.exit_info     = $urandom;
    it.drain_first   = 1'b0;
    return it;
  endfunction

  // Exit item; the registration fields and the unused qualification bits are noise.
  function automatic io_item_t make_exit(logic [15:0] p, logic [2:0] code, logic din,
                                         logic str);
    io_item_t it;
    it.req_type      = pidt_pkg::REQ_DISPATCH;
    it.reg_port      = 16'($urandom);
    it.reg_width_set = 3'($urandom);
    it.reg_has_read  = 1'($urandom);
    it.reg_has_write = 1'($urandom);
    it.exit_info     = {p, 11'($urandom), str, din, code};
    it.drain_first   = 1'b0;
    return it;
  endfunction

  // Driver: record the transfer taken at this edge, then hold, advance or idle.
  // A presented item is never withdrawn while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decision_q.push_back(dispatch_decide(cur));
        xfer_count++;
      end
      if (!in_valid || !in_stall) begin
        if (pending.size() != 0 &&
            !(pending[0].drain_first && decision_q.size() != 0) &&
            (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
          cur = pending.pop_front();
          req_type      <= cur.req_type;
          reg_port      <= cur.reg_port;
          reg_width_set <= cur.reg_width_set;
          reg_has_read  <= cur.reg_has_read;
          reg_has_write <= cur.reg_has_write;
          exit_info     <= cur.exit_info;
          in_valid      <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check every result transfer against the oldest owed decision,
  // and stall the result channel at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        observed.status            = status;
        observed.slot_index        = slot_index;
        observed.use_default       = use_default;
        observed.invoke_handler    = invoke_handler;
        observed.is_write          = is_write;
        observed.access_port       = access_port;
        observed.access_size       = access_size;
        observed.bitmap_byte_index = bitmap_byte_index;
        observed.bitmap_byte_value = bitmap_byte_value;
        if (decision_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: result with nothing owed: %s", fmt_decision(observed));
        end else begin
          wanted = decision_q.pop_front();
          if (observed !== wanted) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: result %0d\n  expected %s\n  actual   %s", result_count,
                       fmt_decision(wanted), fmt_decision(observed));
          end
        end
        result_count++;
      end
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Stimulus and end of run.
  initial begin
    io_item_t it;
    logic [15:0] reg_ports [$];
    logic [15:0] p;
    int k;
    int reg_pct;

    for (k = 0; k < SLOT_COUNT; k++) begin
      slot_taken[k] = 1'b0;
      slot_port[k]  = '0;
      slot_mask[k]  = '0;
      slot_rd[k]    = 1'b0;
      slot_wr[k]    = 1'b0;
    end
    for (k = 0; k < pidt_pkg::BM_BYTES; k++) bitmap_copy[k] = 8'h00;

    // Directed: empty table, string refusal, port extremes, bytes shared in the
    // bitmap, duplicate registration, every size code and both directions.
    pending.push_back(make_exit(16'h0060, 3'd0, 1'b1, 1'b0));   // default handler
    pending.push_back(make_exit(16'h0060, 3'd1, 1'b0, 1'b1));   // string access
    it = make_exit(16'hFFFF, 3'd7, 1'b1, 1'b1);
    it.exit_info = 32'hFFFF_FFFF;
    pending.push_back(it);
    pending.push_back(make_register(16'h0000, 3'b111, 1'b1, 1'b1));
    pending.push_back(make_register(16'hFFFF, 3'b001, 1'b0, 1'b1));
    pending.push_back(make_register(16'h0007, 3'b010, 1'b1, 1'b0));
    pending.push_back(make_register(16'h0000, 3'b100, 1'b0, 1'b0)); // duplicate port
    pending.push_back(make_register(16'h1234, 3'b000, 1'b0, 1'b0)); // no size allowed
    it = make_exit(16'h0000, 3'd0, 1'b0, 1'b0);
    it.exit_info = 32'h0;
    pending.push_back(it);
    pending.push_back(make_exit(16'h0000, 3'd3, 1'b1, 1'b0));   // 4 bytes in
    pending.push_back(make_exit(16'h0000, 3'd1, 1'b0, 1'b0));   // 2 bytes out
    pending.push_back(make_exit(16'h0000, 3'd2, 1'b1, 1'b0));   // 3 bytes: mismatch
    pending.push_back(make_exit(16'h0000, 3'd7, 1'b0, 1'b0));   // 8 bytes: mismatch
    pending.push_back(make_exit(16'h0000, 3'd4, 1'b1, 1'b0));
    pending.push_back(make_exit(16'h0000, 3'd5, 1'b0, 1'b0));
    pending.push_back(make_exit(16'h0000, 3'd6, 1'b1, 1'b0));
    pending.push_back(make_exit(16'hFFFF, 3'd1, 1'b0, 1'b0));   // mask disallows
    pending.push_back(make_exit(16'hFFFF, 3'd0, 1'b1, 1'b0));   // no read routine
    pending.push_back(make_exit(16'hFFFF, 3'd0, 1'b0, 1'b0));
    pending.push_back(make_exit(16'h0007, 3'd1, 1'b1, 1'b0));
    pending.push_back(make_exit(16'h0007, 3'd1, 1'b0, 1'b0));   // no write routine
    pending.push_back(make_exit(16'h1234, 3'd0, 1'b0, 1'b0));
    it = make_exit(16'h0001, 3'd0, 1'b1, 1'b0);
    it.exit_info[15:5] = '1;                                  // junk bits ignored
    pending.push_back(it);
    reg_ports = '{16'h0000, 16'hFFFF, 16'h0007, 16'h0000, 16'h1234};

    // Random: fill the table early, then mostly exits aimed at registered ports,
    // with refused registrations and stray exits mixed in.
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      reg_pct = (reg_ports.size() < SLOT_COUNT) ? 30 : 8;
      if ($urandom_range(0, 99) < reg_pct) begin
        case ($urandom_range(0, 3))
          0, 1: p = 16'h03F8 + 16'($urandom_range(0, 15));
          2:    p = 16'($urandom);
          default: p = reg_ports[$urandom_range(0, reg_ports.size() - 1)];
        endcase
        reg_ports.push_back(p);
        it = make_register(p, 3'($urandom), 1'($urandom), 1'($urandom));
      end else begin
        case ($urandom_range(0, 19))
          0, 1, 2:          p = 16'h03F8 + 16'($urandom_range(0, 15));
          3, 4, 5, 6, 7, 8: p = 16'($urandom);
          default:          p = reg_ports[$urandom_range(0, reg_ports.size() - 1)];
        endcase
        it = make_exit(p, 3'($urandom), 1'($urandom), $urandom_range(0, 9) == 0);
      end
      // Drain the block at the start of the random part and twice more.
      it.drain_first = (k == 0 || k == 300 || k == 650);
      pending.push_back(it);
    end
    total_items = pending.size();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    while (xfer_count < total_items) @(posedge clk);
    while (decision_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Covered %0d transfers: %0d registrations (%0d refused for a full table), %0d exits",
             xfer_count, n_register, n_nospace, xfer_count - n_register);
    $display("Exits: %0d handled by a slot, %0d default, %0d width mismatch, %0d string",
             n_ok, n_default, n_width, n_string);
    if (mismatches == 0 && decision_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Timeout: far beyond the bitmap clearing pass plus the slowest item stream.
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
rtl/pidt_pkg.sv
rtl/pidt_bitmap.sv
rtl/port_io_dispatch_table.sv
dv/port_io_dispatch_table_tb.sv
